// ----- hdl/best_fit_block_allocator_macros.svh -----
// Assertion macros shared by the block's checker.
`ifndef BEST_FIT_BLOCK_ALLOCATOR_MACROS_SVH
`define BEST_FIT_BLOCK_ALLOCATOR_MACROS_SVH
// Checks a property on every clock edge outside reset.
`define BFA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checks that a condition is followed by another one on the next clock edge.
`define BFA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ----- hdl/bfa_pkg.sv -----
// Package with sizes, codes and shared types of the best-fit allocator.
package bfa_pkg;
    localparam int HEAP_SLOTS = 1024;
    localparam int MAX_FREE_BLOCKS = 512;
    localparam int STALE_DEPTH = 64;
    localparam int OFF_W = $clog2(HEAP_SLOTS);
    localparam int SIZE_W = $clog2(HEAP_SLOTS + 1);
    localparam int IDX_W = $clog2(MAX_FREE_BLOCKS);
    localparam int TOT_W = $clog2(MAX_FREE_BLOCKS + 1);
    localparam int SQ_W = $clog2(STALE_DEPTH);
    localparam int SQC_W = $clog2(STALE_DEPTH + 1);
    localparam int FRAME_W = 32;
    localparam int ADDR_W = 48;
    localparam int STRIDE_W = 9;
    localparam int CFG_W = 48;
    localparam int CFG_IDX_W = 2;

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE = 2'd1;
    localparam logic [1:0] OP_RELEASE = 2'd2;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_FEW = 2'd1;
    localparam logic [1:0] ST_NOFIT = 2'd2;
    localparam logic [1:0] ST_QFULL = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_HEAP_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BASE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE = 2'd2;

    typedef enum logic [4:0] {
        S_INIT, S_IDLE, S_DECODE,
        S_SRCH_RD, S_SRCH, S_SRCH_END, S_ALLOC_RD, S_ALLOC_WR,
        S_SHIFT_RD, S_SHIFT_WR, S_INS_RD, S_INS_WR, S_MUL, S_MUL2,
        S_REL_HEAD, S_REL_CHK, S_REL_FIND_RD, S_REL_FIND, S_REL_NEXT_RD,
        S_REL_NEXT, S_REL_APPLY, S_REL_POP, S_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic init;       // reinitialize the table
        logic latch_req;  // capture the input beat
        logic rd_idx;     // read table entry at scan index
        logic scan_clr;   // start a scan at entry zero
        logic scan_inc;
        logic srch_eval;  // compare the read entry for best fit
        logic rd_best;
        logic alloc_wr;   // shrink the best entry
        logic sh_dn_rd;   // read entry k+1 for removal
        logic sh_dn_wr;
        logic sh_up_rd;   // read entry k-1 for insertion
        logic sh_up_wr;
        logic ins_wr;     // write new entry at position p
        logic mul;
        logic mul2;
        logic q_push;
        logic q_rd;
        logic rel_load;   // clip the popped block
        logic find_eval;
        logic rd_prev;
        logic next_eval;
        logic rel_apply;
        logic q_pop;
        logic set_status;
        logic [1:0] status;
        logic out_fill;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] op;
        logic cnt_zero;
        logic cnt_gt_free;
        logic found;
        logic scan_done;     // scan index reached the table total
        logic best_exact;
        logic sh_dn_done;
        logic sh_up_done;
        logic q_full;
        logic q_empty;
        logic head_due;      // head frame at or below threshold
        logic blk_bad;       // size zero or offset at or beyond heap size
        logic find_stop;     // entry offset above block offset
        logic has_prev;
        logic conflict;
        logic need_insert;   // no merge and table has room
        logic drop_full;
        logic mrg_both;
    } stat_t;
endpackage

// ----- hdl/bfa_datapath.sv -----
// Datapath of the allocator: free table, stale queue, search and merge logic.
module bfa_datapath (
    input  logic clk,
    input  logic rst_n,
    input  bfa_pkg::cmd_t cmd,
    output bfa_pkg::stat_t stat,
    input  logic cfg_we,
    input  logic [bfa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bfa_pkg::CFG_W-1:0] cfg_data,
    input  logic [1:0] op,
    input  logic [bfa_pkg::SIZE_W-1:0] count,
    input  logic [bfa_pkg::OFF_W-1:0] block_offset,
    input  logic [bfa_pkg::FRAME_W-1:0] frame,
    output logic [1:0] status,
    output logic [bfa_pkg::OFF_W-1:0] alloc_offset,
    output logic [bfa_pkg::ADDR_W-1:0] handle_address,
    output logic [bfa_pkg::SIZE_W-1:0] free_count
);
    localparam int OW = bfa_pkg::OFF_W;
    localparam int SW = bfa_pkg::SIZE_W;
    localparam int IW = bfa_pkg::IDX_W;
    localparam int TW = bfa_pkg::TOT_W;
    localparam int QW = bfa_pkg::SQ_W;
    localparam int QCW = bfa_pkg::SQC_W;
    localparam int FW = bfa_pkg::FRAME_W;
    localparam int AW = bfa_pkg::ADDR_W;
    localparam int RW = bfa_pkg::STRIDE_W;
    localparam int EW = SW + 1;
    localparam int PW = OW + RW;

    logic [OW-1:0] off_mem [bfa_pkg::MAX_FREE_BLOCKS];
    logic [SW-1:0] size_mem [bfa_pkg::MAX_FREE_BLOCKS];
    logic [OW-1:0] qoff_mem [bfa_pkg::STALE_DEPTH];
    logic [SW-1:0] qsize_mem [bfa_pkg::STALE_DEPTH];
    logic [FW-1:0] qframe_mem [bfa_pkg::STALE_DEPTH];

    logic [SW-1:0] heap_reg, heap_eff;
    logic [AW-1:0] base_reg;
    logic [RW-1:0] stride_reg;
    logic [TW-1:0] total_reg;
    logic [SW-1:0] free_reg;
    logic [QW-1:0] head_reg;
    logic [QCW-1:0] qcnt_reg;

    logic [1:0] op_reg;
    logic [SW-1:0] cnt_reg;
    logic [OW-1:0] boff_reg;
    logic [FW-1:0] frame_reg;

    logic [TW-1:0] k_reg;
    logic [OW-1:0] rd_off_reg;
    logic [SW-1:0] rd_size_reg;
    logic [IW-1:0] best_reg;
    logic [SW-1:0] best_size_reg;
    logic found_reg;
    logic [IW-1:0] wr_idx_reg;

    logic [OW-1:0] qo_reg;
    logic [SW-1:0] qs_reg;
    logic [FW-1:0] qf_reg;
    logic [OW-1:0] b_off_reg;
    logic [SW-1:0] b_size_reg;
    logic [TW-1:0] p_reg;
    logic [OW-1:0] prev_off_reg, next_off_reg;
    logic [SW-1:0] prev_size_reg, next_size_reg;
    logic has_next_reg;
    logic mprev_reg, mnext_reg;
    logic [1:0] mode_reg;

    logic [AW-1:0] prod_reg;
    logic [1:0] st_reg;
    logic [OW-1:0] aoff_reg;
    logic [AW-1:0] haddr_reg;

    localparam logic [1:0] MODE_REMOVE = 2'd0;
    localparam logic [1:0] MODE_INSERT = 2'd1;

    assign heap_eff = (heap_reg > SW'(bfa_pkg::HEAP_SLOTS)) ?
                      SW'(bfa_pkg::HEAP_SLOTS) : heap_reg;

    // Memory write port: one address per cycle.
    logic we;
    logic [IW-1:0] wa;
    logic [OW-1:0] wo;
    logic [SW-1:0] ws;
    logic re;
    logic [IW-1:0] ra;
    logic [EW-1:0] prev_end, blk_end;

    assign prev_end = EW'(prev_off_reg) + EW'(prev_size_reg);
    assign blk_end = EW'(b_off_reg) + EW'(b_size_reg);

    always_comb
    begin
        we = 1'b0;
        wa = wr_idx_reg;
        wo = rd_off_reg;
        ws = rd_size_reg;
        re = 1'b0;
        ra = k_reg[IW-1:0];
        if (cmd.init)
        begin
            we = 1'b1;
            wa = '0;
            wo = '0;
            ws = heap_eff;
        end
        else if (cmd.alloc_wr)
        begin
            we = 1'b1;
            wa = best_reg;
            wo = rd_off_reg + OW'(cnt_reg);
            ws = rd_size_reg - cnt_reg;
        end
        else if (cmd.sh_dn_wr || cmd.sh_up_wr)
        begin
            we = 1'b1;
            wa = k_reg[IW-1:0];
        end
        else if (cmd.ins_wr)
        begin
            we = 1'b1;
            wa = p_reg[IW-1:0];
            wo = b_off_reg;
            ws = b_size_reg;
        end
        else if (cmd.rel_apply)
        begin
            if (mprev_reg)
            begin
                we = 1'b1;
                wa = IW'(p_reg - TW'(1));
                wo = prev_off_reg;
                ws = mnext_reg ? SW'(prev_size_reg + b_size_reg + next_size_reg)
                               : SW'(prev_size_reg + b_size_reg);
            end
            else if (mnext_reg)
            begin
                we = 1'b1;
                wa = p_reg[IW-1:0];
                wo = b_off_reg;
                ws = SW'(b_size_reg + next_size_reg);
            end
        end
        if (cmd.rd_idx)
        begin
            re = 1'b1;
            ra = k_reg[IW-1:0];
        end
        else if (cmd.rd_best)
        begin
            re = 1'b1;
            ra = best_reg;
        end
        else if (cmd.sh_dn_rd)
        begin
            re = 1'b1;
            ra = IW'(k_reg + TW'(1));
        end
        else if (cmd.sh_up_rd)
        begin
            re = 1'b1;
            ra = IW'(k_reg - TW'(1));
        end
        else if (cmd.rd_prev)
        begin
            // The entry just above the block's position is its right neighbor.
            re = 1'b1;
            ra = p_reg[IW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            off_mem[wa] <= wo;
            size_mem[wa] <= ws;
        end
        if (re)
        begin
            rd_off_reg <= off_mem[ra];
            rd_size_reg <= size_mem[ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.q_push)
        begin
            qoff_mem[QW'(head_reg + QW'(qcnt_reg))] <= boff_reg;
            qsize_mem[QW'(head_reg + QW'(qcnt_reg))] <= cnt_reg;
            qframe_mem[QW'(head_reg + QW'(qcnt_reg))] <= frame_reg;
        end
        if (cmd.q_rd)
        begin
            qo_reg <= qoff_mem[head_reg];
            qs_reg <= qsize_mem[head_reg];
            qf_reg <= qframe_mem[head_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_reg <= SW'(1024);
            base_reg <= '0;
            stride_reg <= RW'(32);
            total_reg <= '0;
            free_reg <= '0;
            head_reg <= '0;
            qcnt_reg <= '0;
            k_reg <= '0;
            found_reg <= 1'b0;
            mode_reg <= MODE_REMOVE;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    bfa_pkg::REG_HEAP_SIZE: heap_reg <= cfg_data[SW-1:0];
                    bfa_pkg::REG_BASE:      base_reg <= cfg_data[AW-1:0];
                    bfa_pkg::REG_STRIDE:    stride_reg <= cfg_data[RW-1:0];
                    default: ;
                endcase
            end
            if (cmd.init)
            begin
                total_reg <= (heap_eff != '0) ? TW'(1) : '0;
                free_reg <= heap_eff;
                head_reg <= '0;
                qcnt_reg <= '0;
            end
            if (cmd.scan_clr)
            begin
                k_reg <= '0;
                found_reg <= 1'b0;
            end
            if (cmd.scan_inc)
                k_reg <= k_reg + TW'(1);
            if (cmd.srch_eval && rd_size_reg >= cnt_reg &&
                (!found_reg || rd_size_reg < best_size_reg))
            begin
                found_reg <= 1'b1;
                best_reg <= IW'(k_reg - TW'(1));
                best_size_reg <= rd_size_reg;
            end
            if (cmd.alloc_wr)
            begin
                free_reg <= free_reg - cnt_reg;
                aoff_reg <= rd_off_reg;
                if (best_size_reg == cnt_reg)
                begin
                    // Exact fit: the entry is removed by shifting the tail down.
                    mode_reg <= MODE_REMOVE;
                    k_reg <= TW'(best_reg);
                    total_reg <= total_reg - TW'(1);
                end
            end
            if (cmd.sh_dn_wr)
                k_reg <= k_reg + TW'(1);
            if (cmd.sh_up_wr)
                k_reg <= k_reg - TW'(1);
            if (cmd.q_push)
                qcnt_reg <= qcnt_reg + QCW'(1);
            if (cmd.q_pop)
            begin
                head_reg <= head_reg + QW'(1);
                qcnt_reg <= qcnt_reg - QCW'(1);
            end
            if (cmd.rel_apply)
            begin
                if (mprev_reg && mnext_reg)
                begin
                    mode_reg <= MODE_REMOVE;
                    k_reg <= p_reg;
                    total_reg <= total_reg - TW'(1);
                end
                else if (!mprev_reg && !mnext_reg &&
                         total_reg < TW'(bfa_pkg::MAX_FREE_BLOCKS))
                begin
                    mode_reg <= MODE_INSERT;
                    k_reg <= total_reg;
                    total_reg <= total_reg + TW'(1);
                end
                if (!(!mprev_reg && !mnext_reg && total_reg >=
                      TW'(bfa_pkg::MAX_FREE_BLOCKS)))
                    free_reg <= free_reg + b_size_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_req)
        begin
            op_reg <= op;
            cnt_reg <= count;
            boff_reg <= block_offset;
            frame_reg <= frame;
        end
        if (cmd.rel_load)
        begin
            b_off_reg <= qo_reg;
            b_size_reg <= (qs_reg > heap_eff - SW'(qo_reg)) ?
                          SW'(heap_eff - SW'(qo_reg)) : qs_reg;
        end
        if (cmd.scan_clr)
            p_reg <= '0;
        if (cmd.find_eval && !(rd_off_reg > b_off_reg))
        begin
            p_reg <= k_reg;
            prev_off_reg <= rd_off_reg;
            prev_size_reg <= rd_size_reg;
        end
        if (cmd.rd_prev)
            has_next_reg <= (p_reg < total_reg);
        if (cmd.next_eval)
        begin
            next_off_reg <= rd_off_reg;
            next_size_reg <= rd_size_reg;
            mprev_reg <= (p_reg != '0) && (prev_end == EW'(b_off_reg));
            mnext_reg <= has_next_reg && (blk_end == EW'(rd_off_reg));
        end
        if (cmd.sh_dn_rd || cmd.sh_up_rd)
            wr_idx_reg <= k_reg[IW-1:0];
        if (cmd.mul)
            prod_reg <= AW'(PW'(aoff_reg) * PW'(stride_reg));
        if (cmd.mul2)
            haddr_reg <= base_reg + prod_reg;
        if (cmd.set_status)
            st_reg <= cmd.status;
        if (cmd.out_fill)
        begin
            status <= st_reg;
            alloc_offset <= (st_reg == bfa_pkg::ST_OK && op_reg == bfa_pkg::OP_ALLOC) ?
                            aoff_reg : '0;
            handle_address <= (st_reg == bfa_pkg::ST_OK && op_reg == bfa_pkg::OP_ALLOC) ?
                              haddr_reg : '0;
            free_count <= free_reg;
        end
    end

    // The scan reads entry k at S_SRCH_RD and the release find reads entry k too;
    // p counts how many entries sit at or below the block offset.
    always_comb
    begin
        stat.op = op_reg;
        stat.cnt_zero = (cnt_reg == '0);
        stat.cnt_gt_free = (cnt_reg > free_reg);
        stat.found = found_reg;
        stat.scan_done = (k_reg >= total_reg);
        stat.best_exact = (best_size_reg == cnt_reg);
        stat.sh_dn_done = (mode_reg == MODE_REMOVE) ? (k_reg + TW'(1) >= total_reg + TW'(1))
                          : 1'b0;
        stat.sh_up_done = (k_reg <= p_reg);
        stat.q_full = (qcnt_reg >= QCW'(bfa_pkg::STALE_DEPTH));
        stat.q_empty = (qcnt_reg == '0);
        stat.head_due = (qf_reg <= frame_reg);
        stat.blk_bad = (qs_reg == '0) || (SW'(qo_reg) >= heap_eff);
        stat.find_stop = (rd_off_reg > b_off_reg);
        stat.has_prev = (p_reg != '0);
        stat.conflict = ((p_reg != '0) && (prev_end > EW'(b_off_reg))) ||
                        (has_next_reg && (blk_end > EW'(rd_off_reg)));
        stat.need_insert = !mprev_reg && !mnext_reg &&
                           (total_reg < TW'(bfa_pkg::MAX_FREE_BLOCKS));
        stat.drop_full = !mprev_reg && !mnext_reg &&
                         (total_reg >= TW'(bfa_pkg::MAX_FREE_BLOCKS));
        stat.mrg_both = mprev_reg && mnext_reg;
    end
endmodule

// ----- hdl/bfa_controller.sv -----
// Controller state machine of the allocator.
module bfa_controller (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic [bfa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    input  bfa_pkg::stat_t stat,
    output bfa_pkg::cmd_t cmd
);
    bfa_pkg::state_t state_reg, state_next;
    logic ov_reg, ov_next;
    logic rm_reg, rm_next;   // removal was started by the release path

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bfa_pkg::S_INIT;
            ov_reg <= 1'b0;
            rm_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg <= ov_next;
            rm_reg <= rm_next;
        end
    end

    assign out_valid = ov_reg;

    always_comb
    begin
        state_next = state_reg;
        rm_next = rm_reg;
        ov_next = ov_reg && !out_ready;
        cmd = '0;
        in_ready = 1'b0;
        case (state_reg)
            bfa_pkg::S_INIT:
            begin
                cmd.init = 1'b1;
                state_next = bfa_pkg::S_IDLE;
            end
            bfa_pkg::S_IDLE:
            begin
                in_ready = !ov_reg || out_ready;
                if (cfg_we && cfg_index == bfa_pkg::REG_HEAP_SIZE)
                begin
                    in_ready = 1'b0;
                    state_next = bfa_pkg::S_INIT;
                end
                else if (in_valid && in_ready)
                begin
                    cmd.latch_req = 1'b1;
                    state_next = bfa_pkg::S_DECODE;
                end
            end
            bfa_pkg::S_DECODE:
            begin
                cmd.set_status = 1'b1;
                cmd.status = bfa_pkg::ST_OK;
                cmd.scan_clr = 1'b1;
                state_next = bfa_pkg::S_DONE;
                case (stat.op)
                    bfa_pkg::OP_ALLOC:
                    begin
                        if (stat.cnt_zero)
                            cmd.status = bfa_pkg::ST_NOFIT;
                        else if (stat.cnt_gt_free)
                            cmd.status = bfa_pkg::ST_FEW;
                        else
                            state_next = bfa_pkg::S_SRCH_RD;
                    end
                    bfa_pkg::OP_FREE:
                    begin
                        if (stat.q_full)
                            cmd.status = bfa_pkg::ST_QFULL;
                        else
                            cmd.q_push = 1'b1;
                    end
                    bfa_pkg::OP_RELEASE: state_next = bfa_pkg::S_REL_HEAD;
                    default: ;
                endcase
            end
            bfa_pkg::S_SRCH_RD:
            begin
                if (stat.scan_done)
                    state_next = bfa_pkg::S_SRCH_END;
                else
                begin
                    cmd.rd_idx = 1'b1;
                    cmd.scan_inc = 1'b1;
                    state_next = bfa_pkg::S_SRCH;
                end
            end
            bfa_pkg::S_SRCH:
            begin
                cmd.srch_eval = 1'b1;
                state_next = bfa_pkg::S_SRCH_RD;
            end
            bfa_pkg::S_SRCH_END:
            begin
                if (stat.found)
                begin
                    cmd.rd_best = 1'b1;
                    state_next = bfa_pkg::S_ALLOC_RD;
                end
                else
                begin
                    cmd.set_status = 1'b1;
                    cmd.status = bfa_pkg::ST_NOFIT;
                    state_next = bfa_pkg::S_DONE;
                end
            end
            bfa_pkg::S_ALLOC_RD: state_next = bfa_pkg::S_ALLOC_WR;
            bfa_pkg::S_ALLOC_WR:
            begin
                cmd.alloc_wr = 1'b1;
                rm_next = 1'b0;
                state_next = stat.best_exact ? bfa_pkg::S_SHIFT_RD : bfa_pkg::S_MUL;
            end
            bfa_pkg::S_SHIFT_RD:
            begin
                if (stat.scan_done)
                    state_next = rm_reg ? bfa_pkg::S_REL_POP : bfa_pkg::S_MUL;
                else
                begin
                    cmd.sh_dn_rd = 1'b1;
                    state_next = bfa_pkg::S_SHIFT_WR;
                end
            end
            bfa_pkg::S_SHIFT_WR:
            begin
                cmd.sh_dn_wr = 1'b1;
                state_next = bfa_pkg::S_SHIFT_RD;
            end
            bfa_pkg::S_INS_RD:
            begin
                if (stat.sh_up_done)
                begin
                    cmd.ins_wr = 1'b1;
                    state_next = bfa_pkg::S_REL_POP;
                end
                else
                begin
                    cmd.sh_up_rd = 1'b1;
                    state_next = bfa_pkg::S_INS_WR;
                end
            end
            bfa_pkg::S_INS_WR:
            begin
                cmd.sh_up_wr = 1'b1;
                state_next = bfa_pkg::S_INS_RD;
            end
            bfa_pkg::S_MUL:
            begin
                cmd.mul = 1'b1;
                state_next = bfa_pkg::S_MUL2;
            end
            bfa_pkg::S_MUL2:
            begin
                cmd.mul2 = 1'b1;
                state_next = bfa_pkg::S_DONE;
            end
            bfa_pkg::S_REL_HEAD:
            begin
                if (stat.q_empty)
                    state_next = bfa_pkg::S_DONE;
                else
                begin
                    cmd.q_rd = 1'b1;
                    state_next = bfa_pkg::S_REL_CHK;
                end
            end
            bfa_pkg::S_REL_CHK:
            begin
                if (!stat.head_due)
                    state_next = bfa_pkg::S_DONE;
                else if (stat.blk_bad)
                    state_next = bfa_pkg::S_REL_POP;
                else
                begin
                    cmd.rel_load = 1'b1;
                    cmd.scan_clr = 1'b1;
                    state_next = bfa_pkg::S_REL_FIND_RD;
                end
            end
            bfa_pkg::S_REL_FIND_RD:
            begin
                if (stat.scan_done)
                begin
                    cmd.rd_prev = 1'b1;
                    state_next = bfa_pkg::S_REL_NEXT_RD;
                end
                else
                begin
                    cmd.rd_idx = 1'b1;
                    cmd.scan_inc = 1'b1;
                    state_next = bfa_pkg::S_REL_FIND;
                end
            end
            bfa_pkg::S_REL_FIND:
            begin
                // Table is sorted: stop at the first entry above the block.
                if (stat.find_stop)
                begin
                    cmd.rd_prev = 1'b1;
                    state_next = bfa_pkg::S_REL_NEXT_RD;
                end
                else
                begin
                    cmd.find_eval = 1'b1;
                    state_next = bfa_pkg::S_REL_FIND_RD;
                end
            end
            bfa_pkg::S_REL_NEXT_RD:
            begin
                // The read of entry p (next) was issued by rd_prev at index p.
                state_next = bfa_pkg::S_REL_NEXT;
            end
            bfa_pkg::S_REL_NEXT:
            begin
                cmd.next_eval = 1'b1;
                state_next = stat.conflict ? bfa_pkg::S_REL_POP : bfa_pkg::S_REL_APPLY;
            end
            bfa_pkg::S_REL_APPLY:
            begin
                cmd.rel_apply = 1'b1;
                rm_next = 1'b1;
                if (stat.mrg_both)
                    state_next = bfa_pkg::S_SHIFT_RD;
                else if (stat.need_insert)
                    state_next = bfa_pkg::S_INS_RD;
                else
                    state_next = bfa_pkg::S_REL_POP;
            end
            bfa_pkg::S_REL_POP:
            begin
                cmd.q_pop = 1'b1;
                state_next = bfa_pkg::S_REL_HEAD;
            end
            bfa_pkg::S_DONE:
            begin
                if (!ov_reg || out_ready)
                begin
                    cmd.out_fill = 1'b1;
                    ov_next = 1'b1;
                    state_next = bfa_pkg::S_IDLE;
                end
            end
            default: state_next = bfa_pkg::S_INIT;
        endcase
    end
endmodule

// ----- hdl/best_fit_block_allocator.sv -----
// Top level of the best-fit block allocator.
//  channel | signals                              | direction
//  in      | in_valid in_ready op count ...       | request beat in
//  out     | out_valid out_ready status ...       | result beat out
//  cfg     | cfg_we cfg_index cfg_data            | register write
// Allocate scans all N free-table entries through the single-port table, one read
// and one compare state per entry; a removal or insertion then moves entries one at a time.
// Release walks the table per popped beat; free and reject go from decode to the output.
// Reset, or a heap_size write while idle, rebuilds the table in the S_INIT state.
// A result waits in the output register; a stalled output holds the next beat.
module best_fit_block_allocator (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic [bfa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bfa_pkg::CFG_W-1:0] cfg_data,
    input  logic in_valid,
    output logic in_ready,
    input  logic [1:0] op,
    input  logic [bfa_pkg::SIZE_W-1:0] count,
    input  logic [bfa_pkg::OFF_W-1:0] block_offset,
    input  logic [bfa_pkg::FRAME_W-1:0] frame,
    output logic out_valid,
    input  logic out_ready,
    output logic [1:0] status,
    output logic [bfa_pkg::OFF_W-1:0] alloc_offset,
    output logic [bfa_pkg::ADDR_W-1:0] handle_address,
    output logic [bfa_pkg::SIZE_W-1:0] free_count
);
    bfa_pkg::cmd_t cmd;
    bfa_pkg::stat_t stat;

    bfa_controller u_ctrl (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .in_valid(in_valid), .in_ready(in_ready), .out_valid(out_valid),
        .out_ready(out_ready), .stat(stat), .cmd(cmd)
    );

    bfa_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat), .cfg_we(cfg_we),
        .cfg_index(cfg_index), .cfg_data(cfg_data), .op(op), .count(count),
        .block_offset(block_offset), .frame(frame), .status(status),
        .alloc_offset(alloc_offset), .handle_address(handle_address),
        .free_count(free_count)
    );
endmodule

// ----- hdl/bfa_checker.sv -----
// Port-level checker of the allocator, bound to the top level.
`include "best_fit_block_allocator_macros.svh"
module bfa_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic [1:0] status,
    input logic [bfa_pkg::OFF_W-1:0] alloc_offset,
    input logic [bfa_pkg::ADDR_W-1:0] handle_address,
    input logic [bfa_pkg::SIZE_W-1:0] free_count
);
    logic fail_beat;
    logic grant_zero;
    logic in_beat;
    logic out_wait;
    logic count_ok;

    assign fail_beat = out_valid && (status != bfa_pkg::ST_OK);
    assign grant_zero = (alloc_offset == '0) && (handle_address == '0);
    assign in_beat = in_valid && in_ready;
    assign out_wait = out_valid && !out_ready;
    assign count_ok = free_count <= bfa_pkg::SIZE_W'(bfa_pkg::HEAP_SLOTS);

    `BFA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_wait, out_valid, "out beat dropped")
    `BFA_ASSERT(a_fail_zero, clk, rst_n, fail_beat |-> grant_zero, "failed beat has an offset")
    `BFA_ASSERT_NEXT(a_one_at_time, clk, rst_n, in_beat, !in_ready, "second beat taken")
    `BFA_ASSERT(a_free_range, clk, rst_n, out_valid |-> count_ok, "free count above heap")
endmodule

bind best_fit_block_allocator bfa_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .status(status),
    .alloc_offset(alloc_offset), .handle_address(handle_address),
    .free_count(free_count)
);
